// File: design/dic_pkg.sv
// shared types, codes and control word layout for the in-circle checker
package dic_pkg;

    localparam int NUM_CFG_REGS = 6;
    localparam int CFG_IDX_BITS = 3;
    localparam int STEP_BITS    = 5;

    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_A_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_A_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_B_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_B_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_C_X = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_C_Y = 3'd5;

    typedef enum logic [4:0] {
        SRC_X0, SRC_X1, SRC_X2,
        SRC_Y0, SRC_Y1, SRC_Y2,
        SRC_SL0, SRC_SL1, SRC_SL2,
        SRC_SH0, SRC_SH1, SRC_SH2,
        SRC_CL0, SRC_CL1, SRC_CL2,
        SRC_CH0, SRC_CH1, SRC_CH2
    } t_src;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef enum logic [1:0] {
        SH_0,
        SH_L,
        SH_2L
    } t_shift;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_S0, DST_S1, DST_S2,
        DST_C0, DST_C1, DST_C2
    } t_dst;

    typedef enum logic [1:0] {
        CND_NEXT,
        CND_WAIT_IN,
        CND_WAIT_OUT,
        CND_JUMP
    } t_cond;

    typedef struct packed {
        t_src                 src_a;
        t_src                 src_b;
        t_acc_op              acc_op;
        t_shift               acc_shift;
        t_dst                 dst;
        t_cond                cond;
        logic [STEP_BITS-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_seq_status;

    typedef struct packed {
        logic idle;
        logic eval;
    } t_seq_flags;

endpackage

// File: design/dic_sequencer.sv
// microprogram rom, step counter and jump logic
module dic_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dic_pkg::t_seq_status i_status,
    output dic_pkg::t_ctrl       o_ctrl,
    output dic_pkg::t_seq_flags  o_flags
);
    import dic_pkg::*;

    logic [STEP_BITS-1:0] r_step;
    logic [STEP_BITS-1:0] n_step;
    t_ctrl                ctrl;

    function automatic t_ctrl mk(t_src a, t_src b, t_acc_op op, t_shift sh, t_dst dst,
                                 t_cond cond, logic [STEP_BITS-1:0] tgt);
        t_ctrl w;
        w.src_a     = a;
        w.src_b     = b;
        w.acc_op    = op;
        w.acc_shift = sh;
        w.dst       = dst;
        w.cond      = cond;
        w.target    = tgt;
        return w;
    endfunction

    function automatic t_ctrl rom(logic [STEP_BITS-1:0] step);
        t_ctrl w;
        case (step)
            // wait for a point, latch the differences
            5'd0:  w = mk(SRC_X0, SRC_X0, ACC_NONE, SH_0, DST_NONE, CND_WAIT_IN, 5'd1);
            // squared distances
            5'd1:  w = mk(SRC_X0, SRC_X0, ACC_NONE, SH_0, DST_NONE, CND_NEXT, 5'd0);
            5'd2:  w = mk(SRC_Y0, SRC_Y0, ACC_LOAD, SH_0, DST_NONE, CND_NEXT, 5'd0);
            5'd3:  w = mk(SRC_X1, SRC_X1, ACC_ADD,  SH_0, DST_NONE, CND_NEXT, 5'd0);
            5'd4:  w = mk(SRC_Y1, SRC_Y1, ACC_LOAD, SH_0, DST_S0,   CND_NEXT, 5'd0);
            5'd5:  w = mk(SRC_X2, SRC_X2, ACC_ADD,  SH_0, DST_NONE, CND_NEXT, 5'd0);
            5'd6:  w = mk(SRC_Y2, SRC_Y2, ACC_LOAD, SH_0, DST_S1,   CND_NEXT, 5'd0);
            // 2x2 minors
            5'd7:  w = mk(SRC_X1, SRC_Y2, ACC_ADD,  SH_0, DST_NONE, CND_NEXT, 5'd0);
            5'd8:  w = mk(SRC_X2, SRC_Y1, ACC_LOAD, SH_0, DST_S2,   CND_NEXT, 5'd0);
            5'd9:  w = mk(SRC_X0, SRC_Y2, ACC_SUB,  SH_0, DST_NONE, CND_NEXT, 5'd0);
            5'd10: w = mk(SRC_X2, SRC_Y0, ACC_LOAD, SH_0, DST_C0,   CND_NEXT, 5'd0);
            5'd11: w = mk(SRC_X0, SRC_Y1, ACC_SUB,  SH_0, DST_NONE, CND_NEXT, 5'd0);
            5'd12: w = mk(SRC_X1, SRC_Y0, ACC_LOAD, SH_0, DST_C1,   CND_NEXT, 5'd0);
            5'd13: w = mk(SRC_SL0, SRC_CL0, ACC_SUB, SH_0, DST_NONE, CND_NEXT, 5'd0);
            // determinant from split partial products
            5'd14: w = mk(SRC_SL0, SRC_CH0, ACC_LOAD, SH_0,  DST_C2,   CND_NEXT, 5'd0);
            5'd15: w = mk(SRC_SH0, SRC_CL0, ACC_ADD,  SH_L,  DST_NONE, CND_NEXT, 5'd0);
            5'd16: w = mk(SRC_SH0, SRC_CH0, ACC_ADD,  SH_L,  DST_NONE, CND_NEXT, 5'd0);
            5'd17: w = mk(SRC_SL1, SRC_CL1, ACC_ADD,  SH_2L, DST_NONE, CND_NEXT, 5'd0);
            5'd18: w = mk(SRC_SL1, SRC_CH1, ACC_SUB,  SH_0,  DST_NONE, CND_NEXT, 5'd0);
            5'd19: w = mk(SRC_SH1, SRC_CL1, ACC_SUB,  SH_L,  DST_NONE, CND_NEXT, 5'd0);
            5'd20: w = mk(SRC_SH1, SRC_CH1, ACC_SUB,  SH_L,  DST_NONE, CND_NEXT, 5'd0);
            5'd21: w = mk(SRC_SL2, SRC_CL2, ACC_SUB,  SH_2L, DST_NONE, CND_NEXT, 5'd0);
            5'd22: w = mk(SRC_SL2, SRC_CH2, ACC_ADD,  SH_0,  DST_NONE, CND_NEXT, 5'd0);
            5'd23: w = mk(SRC_SH2, SRC_CL2, ACC_ADD,  SH_L,  DST_NONE, CND_NEXT, 5'd0);
            5'd24: w = mk(SRC_SH2, SRC_CH2, ACC_ADD,  SH_L,  DST_NONE, CND_NEXT, 5'd0);
            5'd25: w = mk(SRC_X0,  SRC_X0,  ACC_ADD,  SH_2L, DST_NONE, CND_NEXT, 5'd0);
            // sign test and result write
            5'd26: w = mk(SRC_X0, SRC_X0, ACC_NONE, SH_0, DST_NONE, CND_WAIT_OUT, 5'd0);
            default: w = mk(SRC_X0, SRC_X0, ACC_NONE, SH_0, DST_NONE, CND_JUMP, 5'd0);
        endcase
        return w;
    endfunction

    assign ctrl = rom(r_step);

    always_comb begin
        case (ctrl.cond)
            CND_NEXT:     n_step = r_step + 1'b1;
            CND_WAIT_IN:  n_step = i_status.in_valid ? ctrl.target : r_step;
            CND_WAIT_OUT: n_step = i_status.out_free ? ctrl.target : r_step;
            CND_JUMP:     n_step = ctrl.target;
            default:      n_step = ctrl.target;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl       = ctrl;
    assign o_flags.idle = (ctrl.cond == CND_WAIT_IN);
    assign o_flags.eval = (ctrl.cond == CND_WAIT_OUT) && i_status.out_free;

endmodule

// File: design/dic_datapath.sv
// difference registers, shared multiplier, accumulator and partial result stores
module dic_datapath #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  dic_pkg::t_ctrl               i_ctrl,
    input  logic                         i_load,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic signed [COORD_BITS-1:0] i_vertex [dic_pkg::NUM_CFG_REGS],
    output logic                         o_not_inside
);
    import dic_pkg::*;

    localparam int DW   = COORD_BITS + 1;       // coordinate difference
    localparam int LW   = COORD_BITS + 2;       // low split of a stored value
    localparam int MW   = LW + 1;               // multiplier operand
    localparam int SW   = 2 * COORD_BITS + 3;   // squared distance or minor
    localparam int HW   = SW - LW;              // high split of a stored value
    localparam int PW   = 2 * MW;               // product
    localparam int AW   = 4 * COORD_BITS + 10;  // accumulator
    localparam int DEXT = MW - DW;
    localparam int HEXT = MW - HW;
    localparam int PEXT = AW - PW;
    localparam int SH1  = LW;
    localparam int SH2  = 2 * LW;

    logic signed [DW-1:0] r_x0, r_x1, r_x2, r_y0, r_y1, r_y2;
    logic signed [SW-1:0] r_s0, r_s1, r_s2, r_c0, r_c1, r_c2;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;
    logic signed [MW-1:0] op_a, op_b;
    logic signed [AW-1:0] prod_ext, addend;

    function automatic logic signed [MW-1:0] ext_d(logic signed [DW-1:0] v);
        return {{DEXT{v[DW-1]}}, v};
    endfunction

    function automatic logic signed [MW-1:0] lo_part(logic signed [SW-1:0] v);
        return {1'b0, v[LW-1:0]};
    endfunction

    function automatic logic signed [MW-1:0] hi_part(logic signed [SW-1:0] v);
        return {{HEXT{v[SW-1]}}, v[SW-1:LW]};
    endfunction

    function automatic logic signed [MW-1:0] pick(
        t_src sel,
        logic signed [DW-1:0] x0, logic signed [DW-1:0] x1, logic signed [DW-1:0] x2,
        logic signed [DW-1:0] y0, logic signed [DW-1:0] y1, logic signed [DW-1:0] y2,
        logic signed [SW-1:0] s0, logic signed [SW-1:0] s1, logic signed [SW-1:0] s2,
        logic signed [SW-1:0] c0, logic signed [SW-1:0] c1, logic signed [SW-1:0] c2);
        logic signed [MW-1:0] v;
        case (sel)
            SRC_X0:  v = ext_d(x0);
            SRC_X1:  v = ext_d(x1);
            SRC_X2:  v = ext_d(x2);
            SRC_Y0:  v = ext_d(y0);
            SRC_Y1:  v = ext_d(y1);
            SRC_Y2:  v = ext_d(y2);
            SRC_SL0: v = lo_part(s0);
            SRC_SL1: v = lo_part(s1);
            SRC_SL2: v = lo_part(s2);
            SRC_SH0: v = hi_part(s0);
            SRC_SH1: v = hi_part(s1);
            SRC_SH2: v = hi_part(s2);
            SRC_CL0: v = lo_part(c0);
            SRC_CL1: v = lo_part(c1);
            SRC_CL2: v = lo_part(c2);
            SRC_CH0: v = hi_part(c0);
            SRC_CH1: v = hi_part(c1);
            SRC_CH2: v = hi_part(c2);
            default: v = '0;
        endcase
        return v;
    endfunction

    assign op_a = pick(i_ctrl.src_a, r_x0, r_x1, r_x2, r_y0, r_y1, r_y2,
                       r_s0, r_s1, r_s2, r_c0, r_c1, r_c2);
    assign op_b = pick(i_ctrl.src_b, r_x0, r_x1, r_x2, r_y0, r_y1, r_y2,
                       r_s0, r_s1, r_s2, r_c0, r_c1, r_c2);

    assign prod_ext = {{PEXT{r_prod[PW-1]}}, r_prod};

    always_comb begin
        case (i_ctrl.acc_shift)
            SH_0:    addend = prod_ext;
            SH_L:    addend = prod_ext <<< SH1;
            SH_2L:   addend = prod_ext <<< SH2;
            default: addend = prod_ext;
        endcase
    end

    always_comb begin
        case (i_ctrl.acc_op)
            ACC_NONE: n_acc = r_acc;
            ACC_LOAD: n_acc = addend;
            ACC_ADD:  n_acc = r_acc + addend;
            ACC_SUB:  n_acc = r_acc - addend;
            default:  n_acc = r_acc;
        endcase
    end

    // point differences, one x word and one y word per vertex
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x0 <= DW'(i_vertex[0]) - DW'(i_point_x);
            r_y0 <= DW'(i_vertex[1]) - DW'(i_point_y);
            r_x1 <= DW'(i_vertex[2]) - DW'(i_point_x);
            r_y1 <= DW'(i_vertex[3]) - DW'(i_point_y);
            r_x2 <= DW'(i_vertex[4]) - DW'(i_point_x);
            r_y2 <= DW'(i_vertex[5]) - DW'(i_point_y);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
        r_acc  <= n_acc;
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.dst)
            DST_S0:  r_s0 <= r_acc[SW-1:0];
            DST_S1:  r_s1 <= r_acc[SW-1:0];
            DST_S2:  r_s2 <= r_acc[SW-1:0];
            DST_C0:  r_c0 <= r_acc[SW-1:0];
            DST_C1:  r_c1 <= r_acc[SW-1:0];
            DST_C2:  r_c2 <= r_acc[SW-1:0];
            default: ;
        endcase
    end

    assign o_not_inside = r_acc[AW-1] || (r_acc == '0);

endmodule

// File: design/delaunay_incircle_check.sv
// top level of the in-circle checker: config registers, verdict and result register
//
//  channel   signals                                         direction
//  point     i_in_valid o_in_stall i_point_x i_point_y       in
//            i_set_end
//  result    o_out_valid i_out_stall o_not_inside            out
//            o_verdict_so_far o_verdict_final
//  config    i_cfg_wr_en i_cfg_index i_cfg_wr_data           in
//
//  a point passes through the accept step, 25 microcode steps that share one
//  multiplier and one accumulator, and the result step
//  the result register holds a finished transaction while the next point is taken
//  reset clears the step counter, the verdict (to one), the result valid and the vertices
//  a stalled result holds the sequencer in its result step until the slot frees
module delaunay_incircle_check #(
    parameter int COORD_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [dic_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [COORD_BITS-1:0]              i_cfg_wr_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [COORD_BITS-1:0]       i_point_x,
    input  logic signed [COORD_BITS-1:0]       i_point_y,
    input  logic                               i_set_end,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_not_inside,
    output logic                               o_verdict_so_far,
    output logic                               o_verdict_final
);
    import dic_pkg::*;

    logic signed [COORD_BITS-1:0] r_vertex [NUM_CFG_REGS];
    logic        r_set_end;
    logic        r_verdict;
    logic        r_out_valid;
    logic        r_not_inside;
    logic        r_so_far;
    logic        r_final;
    logic        n_verdict;
    logic        accept;
    logic        not_inside;
    t_ctrl       ctrl;
    t_seq_status status;
    t_seq_flags  flags;

    assign status.in_valid = i_in_valid;
    assign status.out_free = !r_out_valid || !i_out_stall;

    dic_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_flags  (flags)
    );

    assign o_in_stall = !flags.idle || !i_rst_n;
    assign accept     = i_in_valid && !o_in_stall;

    dic_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_ctrl       (ctrl),
        .i_load       (accept),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_vertex     (r_vertex),
        .o_not_inside (not_inside)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG_REGS; i++) begin
                r_vertex[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_VERTEX_A_X: r_vertex[0] <= i_cfg_wr_data;
                REG_VERTEX_A_Y: r_vertex[1] <= i_cfg_wr_data;
                REG_VERTEX_B_X: r_vertex[2] <= i_cfg_wr_data;
                REG_VERTEX_B_Y: r_vertex[3] <= i_cfg_wr_data;
                REG_VERTEX_C_X: r_vertex[4] <= i_cfg_wr_data;
                REG_VERTEX_C_Y: r_vertex[5] <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_set_end <= i_set_end;
        end
    end

    assign n_verdict = r_verdict && not_inside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_verdict   <= 1'b1;
            r_out_valid <= 1'b0;
        end else if (flags.eval) begin
            r_verdict   <= r_set_end ? 1'b1 : n_verdict;
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (flags.eval) begin
            r_not_inside <= not_inside;
            r_so_far     <= n_verdict;
            r_final      <= r_set_end;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_not_inside     = r_not_inside;
    assign o_verdict_so_far = r_so_far;
    assign o_verdict_final  = r_final;

endmodule

// File: sim/testbench.sv
// self-checking testbench for the in-circle checker: random triangles and point streams
module testbench;
    import dic_pkg::*;

    localparam int CW = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = CFG_IDX_BITS'(NUM_CFG_REGS);
    localparam int PHASE_POINTS = 112;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 last;
    } point_t;

    typedef struct packed {
        logic not_inside;
        logic verdict_so_far;
        logic verdict_final;
    } verdict_t;

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CW-1:0]           i_cfg_wr_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic signed [CW-1:0]    i_point_x = '0;
    logic signed [CW-1:0]    i_point_y = '0;
    logic                    i_set_end = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic                    o_not_inside;
    logic                    o_verdict_so_far;
    logic                    o_verdict_final;

    // mirror of the vertex registers and of the running set verdict
    logic signed [CW-1:0] vertex_mirror [0:NUM_CFG_REGS-1];
    logic                 set_verdict = 1'b1;

    point_t   pending_points[$];
    verdict_t verdicts_due[$];

    int items_queued = 0;
    int points_accepted = 0;
    int results_seen = 0;
    int failures = 0;
    int inside_count = 0;
    int sets_closed = 0;
    int vertex_settings = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    int long_holds = 0;
    int seg_left = 0;

    delaunay_incircle_check #(
        .COORD_BITS(CW)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_point_x(i_point_x),
        .i_point_y(i_point_y),
        .i_set_end(i_set_end),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_not_inside(o_not_inside),
        .o_verdict_so_far(o_verdict_so_far),
        .o_verdict_final(o_verdict_final)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    // exact sign of the in-circle determinant, true when on or outside the circle
    function automatic logic on_or_outside(input logic signed [CW-1:0] px,
                                           input logic signed [CW-1:0] py);
        longint dx [0:2];
        longint dy [0:2];
        longint sq [0:2];
        logic signed [127:0] s0, s1, s2, m0, m1, m2, det;
        int k;
        for (k = 0; k < 3; k++) begin
            dx[k] = longint'(vertex_mirror[2*k]) - longint'(px);
            dy[k] = longint'(vertex_mirror[2*k+1]) - longint'(py);
            sq[k] = dx[k] * dx[k] + dy[k] * dy[k];
        end
        s0 = sq[0];
        s1 = sq[1];
        s2 = sq[2];
        m0 = dx[1] * dy[2] - dx[2] * dy[1];
        m1 = dx[0] * dy[2] - dx[2] * dy[0];
        m2 = dx[0] * dy[1] - dx[1] * dy[0];
        det = s0 * m0 - s1 * m1 + s2 * m2;
        return det <= 0;
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(input int span);
        int v;
        if (span >= 32768)
            return CW'($urandom);
        v = int'($urandom_range(0, 2 * span)) - span;
        return CW'(v);
    endfunction

    // point driver: bursts of random length separated by random gaps
    always @(posedge i_clk) begin
        point_t   nxt;
        verdict_t want;
        logic     ni;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                ni = on_or_outside(i_point_x, i_point_y);
                want.not_inside = ni;
                want.verdict_so_far = set_verdict & ni;
                want.verdict_final = i_set_end;
                verdicts_due.push_back(want);
                set_verdict <= i_set_end ? 1'b1 : (set_verdict & ni);
                points_accepted++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_points.size() != 0) begin
                    nxt = pending_points.pop_front();
                    i_point_x <= nxt.x;
                    i_point_y <= nxt.y;
                    i_set_end <= nxt.last;
                    i_in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 20);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 35);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result stall pattern with occasional long hold-offs to back up the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (long_holds < 3 && points_accepted >= 250 * (long_holds + 1)
                     && pending_points.size() > 40) begin
            long_holds++;
            hold_left <= 400;
            i_out_stall <= 1'b1;
        end else if (seg_left != 0) begin
            seg_left <= seg_left - 1;
        end else begin
            i_out_stall <= ~i_out_stall;
            if (i_out_stall)
                seg_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                        : $urandom_range(0, 25);
            else
                seg_left <= $urandom_range(0, 20);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        verdict_t got;
        verdict_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            got = {o_not_inside, o_verdict_so_far, o_verdict_final};
            if (!got.not_inside)
                inside_count++;
            if (got.verdict_final)
                sets_closed++;
            if (verdicts_due.size() == 0) begin
                $display("%0t unexpected transaction: expected none, actual %b", $time, got);
                failures++;
            end else begin
                want = verdicts_due.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch not_inside/so_far/final: expected %b actual %b",
                             $time, want, got);
                    failures++;
                end
            end
        end
    end

    task automatic queue_point(input logic signed [CW-1:0] px,
                               input logic signed [CW-1:0] py, input logic last);
        point_t p;
        p.x = px;
        p.y = py;
        p.last = last;
        pending_points.push_back(p);
        items_queued++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CW-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx < NUM_CFG_REGS)
            vertex_mirror[idx] = val;
    endtask

    task automatic load_triangle(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                                 input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
                                 input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy);
        write_reg(REG_VERTEX_A_X, ax);
        write_reg(REG_VERTEX_A_Y, ay);
        write_reg(REG_VERTEX_B_X, bx);
        write_reg(REG_VERTEX_B_Y, by);
        write_reg(REG_VERTEX_C_X, cx);
        write_reg(REG_VERTEX_C_Y, cy);
        // spare indexes must leave the vertices alone
        write_reg(CFG_IDX_SPARE + CFG_IDX_BITS'($urandom_range(0, 1)), CW'($urandom));
        vertex_settings++;
    endtask

    task automatic wait_idle();
        while (results_seen != items_queued)
            @(posedge i_clk);
    endtask

    initial begin
        int ph, n, span, set_left, pick, k;
        logic signed [CW-1:0] px, py, qx, qy, ux, uy;
        logic last;

        for (k = 0; k < NUM_CFG_REGS; k++)
            vertex_mirror[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all-zero vertices after reset: collinear, nothing is inside
        queue_point(-16'sd32768, -16'sd32768, 1'b0);
        queue_point(16'sd32767, 16'sd32767, 1'b0);
        queue_point(16'sd0, 16'sd0, 1'b1);
        queue_point(-16'sd32768, 16'sd32767, 1'b1);
        wait_idle();

        // counter-clockwise triangle on the radius-5 circle
        load_triangle(16'sd5, 16'sd0, 16'sd0, 16'sd5, -16'sd5, 16'sd0);
        queue_point(16'sd0, 16'sd0, 1'b0);
        queue_point(16'sd3, 16'sd4, 1'b0);
        queue_point(16'sd0, -16'sd5, 1'b0);
        queue_point(16'sd1, 16'sd1, 1'b1);
        queue_point(16'sd3, -16'sd4, 1'b0);
        queue_point(16'sd5, 16'sd0, 1'b0);
        queue_point(-16'sd4, 16'sd3, 1'b0);
        queue_point(16'sd32767, -16'sd32768, 1'b1);
        queue_point(16'sd0, -16'sd4, 1'b1);
        wait_idle();

        // clockwise order flips the sign test
        load_triangle(16'sd5, 16'sd0, -16'sd5, 16'sd0, 16'sd0, 16'sd5);
        queue_point(16'sd0, 16'sd0, 1'b0);
        queue_point(16'sd100, 16'sd0, 1'b1);
        queue_point(16'sd0, -16'sd5, 1'b1);
        wait_idle();

        for (ph = 0; ph < 10; ph++) begin
            case (ph % 5)
                0: begin
                    load_triangle(rand_coord(200), rand_coord(200), rand_coord(200),
                                  rand_coord(200), rand_coord(200), rand_coord(200));
                    span = 300;
                end
                1: begin
                    load_triangle(rand_coord(32768), rand_coord(32768), rand_coord(32768),
                                  rand_coord(32768), rand_coord(32768), rand_coord(32768));
                    span = 32768;
                end
                2: begin
                    if (ph < 5)
                        load_triangle(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
                                      16'sd32767, 16'sd32767);
                    else
                        load_triangle(16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
                                      -16'sd32768, -16'sd32768);
                    span = 32768;
                end
                3: begin
                    px = rand_coord(1000);
                    py = rand_coord(1000);
                    qx = rand_coord(500);
                    qy = rand_coord(500);
                    ux = px + qx;
                    uy = py + qy;
                    load_triangle(px, py, ux, uy, ux + qx, uy + qy);
                    span = 2500;
                end
                default: begin
                    load_triangle(rand_coord(5000), rand_coord(5000), rand_coord(5000),
                                  rand_coord(5000), rand_coord(5000), rand_coord(5000));
                    span = 6000;
                end
            endcase
            set_left = $urandom_range(1, 12);
            for (n = 0; n < PHASE_POINTS; n++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    k = $urandom_range(0, 2);
                    px = vertex_mirror[2*k];
                    py = vertex_mirror[2*k+1];
                end else if (pick == 1) begin
                    px = rand_coord(32768);
                    py = rand_coord(32768);
                end else begin
                    px = rand_coord(span);
                    py = rand_coord(span);
                end
                set_left--;
                last = (set_left == 0);
                if (last)
                    set_left = $urandom_range(1, 12);
                queue_point(px, py, last);
            end
            wait_idle();
        end

        repeat (40) @(posedge i_clk);
        if (verdicts_due.size() != 0) begin
            $display("%0t %0d expected transactions never arrived", $time, verdicts_due.size());
            failures++;
        end
        $display("checked %0d points under %0d vertex settings: %0d inside, %0d sets closed",
                 points_accepted, vertex_settings, inside_count, sets_closed);
        $display("long result hold-offs: %0d", long_holds);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
design/dic_pkg.sv
design/dic_sequencer.sv
design/dic_datapath.sv
design/delaunay_incircle_check.sv
sim/testbench.sv
